@@ rtl/lrs_pkg.sv @@
// Shared types and constants for the range-add / range-sum tree.
package lrs_pkg;

  localparam int PosW   = 12;  // position width, one bit above the 11-bit fields
  localparam int FieldW = 11;
  localparam int DeltaW = 32;
  localparam int SumW   = 64;
  localparam int MulAW  = 33;  // signed operand of the shared multiplier
  localparam int MulBW  = 12;  // unsigned operand of the shared multiplier
  localparam int MulPW  = MulAW + MulBW + 1;

  localparam logic CmdAdd   = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef logic [SumW-1:0] sum_t;
  typedef logic [PosW-1:0] pos_t;

  // One Fenwick entry: coefficient tree and correction tree side by side.
  typedef struct packed {
    sum_t b1;
    sum_t b2;
  } pair_t;

endpackage

@@ rtl/lazy_range_add_sum_tree.sv @@
// Top level: range add / range sum over two Fenwick trees, one sequencer.
//
//  channel   direction  handshake                 payload
//  request   in         start_i, busy_o           cmd_i, range_left_i, range_right_i, delta_i
//  result    out        done_o (one-cycle strobe) range_sum_o
//  config    in         cfg_valid_i, cfg_ready_o  cfg_data_i (active_size)
//
// An add walks the tree from range_left_i and, unless range_right_i is the last position,
// again from range_right_i+1, a read and a write per node through the single RAM port.
// A query makes one prefix walk, or two when range_left_i is above 1, each closed by two
// passes through the shared multiplier. Out-of-bounds or empty requests never raise busy_o.
// After reset and after every active_size write a clearing pass over all min(SIZE,2047)+1
// RAM entries runs with busy_o high. Config is taken only while idle and no request is
// offered. done_o cannot be stalled.
module lazy_range_add_sum_tree #(
  parameter int SIZE = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              cmd_i,
  input  logic [lrs_pkg::FieldW-1:0]        range_left_i,
  input  logic [lrs_pkg::FieldW-1:0]        range_right_i,
  input  logic signed [lrs_pkg::DeltaW-1:0] delta_i,
  output logic                              done_o,
  output logic signed [lrs_pkg::SumW-1:0]   range_sum_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lrs_pkg::FieldW-1:0]        cfg_data_i
);

  localparam int MaxPos    = (SIZE < 2047) ? SIZE : 2047;
  localparam int MemDepth  = MaxPos + 1;
  localparam int AW        = $clog2(MemDepth);
  localparam int SizeReset = (MaxPos < 1024) ? MaxPos : 1024;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MUL, S_MW, S_RD, S_UPD,
    S_QRD, S_QACC, S_MLO, S_MHI, S_COMB, S_FIN
  } state_e;

  state_e state_q;
  logic   phase_q;
  logic [AW-1:0] clr_q;
  lrs_pkg::pos_t size_q, l_q, r_q, idx_q, x_q;
  logic signed [lrs_pkg::DeltaW-1:0] d_q;
  lrs_pkg::sum_t v1_q, v2_q, acc1_q, acc2_q, t_q, res_q, sum_q;
  logic done_q;

  lrs_pkg::pos_t in_l, in_r, lowbit, idx_up, idx_dn, cfg_sat;
  logic          in_ok;
  lrs_pkg::sum_t d_ext, prod;
  lrs_pkg::pair_t rdata, wdata;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic signed [lrs_pkg::MulAW-1:0] mul_a;
  logic [lrs_pkg::MulBW-1:0]        mul_b;

  assign in_l   = {1'b0, range_left_i};
  assign in_r   = {1'b0, range_right_i};
  assign in_ok  = (in_l != '0) && (in_l <= in_r) && (in_r <= size_q);
  assign lowbit = idx_q & (~idx_q + lrs_pkg::PosW'(1));
  assign idx_up = idx_q + lowbit;
  assign idx_dn = idx_q - lowbit;
  assign d_ext  = {{(lrs_pkg::SumW - lrs_pkg::DeltaW){d_q[lrs_pkg::DeltaW-1]}}, d_q};

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_sat = lrs_pkg::PosW'(1);
    end else if ({1'b0, cfg_data_i} > lrs_pkg::PosW'(MaxPos)) begin
      cfg_sat = lrs_pkg::PosW'(MaxPos);
    end else begin
      cfg_sat = {1'b0, cfg_data_i};
    end
  end

  // multiplier operand select
  always_comb begin
    case (state_q)
      S_MUL: begin
        mul_a = {d_q[lrs_pkg::DeltaW-1], d_q};
        mul_b = phase_q ? r_q : (l_q - lrs_pkg::PosW'(1));
      end
      S_MHI: begin
        mul_a = {1'b0, acc1_q[63:32]};
        mul_b = x_q;
      end
      default: begin
        mul_a = {1'b0, acc1_q[31:0]};
        mul_b = x_q;
      end
    endcase
  end

  lrs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = idx_q[AW-1:0];
    wdata.b1 = rdata.b1 + v1_q;
    wdata.b2 = rdata.b2 + v2_q;
    case (state_q)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        wdata    = '0;
      end
      S_UPD: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lrs_ram #(
    .Depth (MemDepth),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      size_q  <= lrs_pkg::PosW'(SizeReset);
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q  <= cfg_sat;
        clr_q   <= '0;
        state_q <= S_CLR;
      end else begin
        case (state_q)
          S_CLR: begin
            if (clr_q == AW'(MaxPos)) begin
              state_q <= S_IDLE;
            end else begin
              clr_q <= clr_q + AW'(1);
            end
          end
          S_IDLE: begin
            if (start_i) begin
              l_q     <= in_l;
              r_q     <= in_r;
              d_q     <= delta_i;
              phase_q <= 1'b0;
              x_q     <= in_r;
              idx_q   <= in_r;
              acc1_q  <= '0;
              acc2_q  <= '0;
              res_q   <= '0;
              if (!in_ok) begin
                if (cmd_i == lrs_pkg::CmdQuery) begin
                  sum_q  <= '0;
                  done_q <= 1'b1;
                end
              end else if (cmd_i == lrs_pkg::CmdAdd) begin
                state_q <= S_MUL;
              end else begin
                state_q <= S_QRD;
              end
            end
          end
          S_MUL: begin
            state_q <= S_MW;
          end
          S_MW: begin
            v1_q <= phase_q ? (lrs_pkg::sum_t'(0) - d_ext) : d_ext;
            v2_q <= phase_q ? (lrs_pkg::sum_t'(0) - prod) : prod;
            idx_q <= phase_q ? (r_q + lrs_pkg::PosW'(1)) : l_q;
            if (phase_q && (r_q + lrs_pkg::PosW'(1) > size_q)) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_RD;
            end
          end
          S_RD: begin
            state_q <= S_UPD;
          end
          S_UPD: begin
            idx_q <= idx_up;
            if (idx_up <= size_q) begin
              state_q <= S_RD;
            end else if (!phase_q) begin
              phase_q <= 1'b1;
              state_q <= S_MUL;
            end else begin
              state_q <= S_IDLE;
            end
          end
          S_QRD: begin
            state_q <= S_QACC;
          end
          S_QACC: begin
            acc1_q <= acc1_q + rdata.b1;
            acc2_q <= acc2_q + rdata.b2;
            idx_q  <= idx_dn;
            state_q <= (idx_dn != '0) ? S_QRD : S_MLO;
          end
          S_MLO: begin
            state_q <= S_MHI;
          end
          S_MHI: begin
            t_q     <= prod - acc2_q;
            state_q <= S_COMB;
          end
          S_COMB: begin
            t_q     <= t_q + {prod[31:0], 32'b0};
            state_q <= S_FIN;
          end
          S_FIN: begin
            // prefix(r) minus prefix(l-1)
            if (!phase_q) begin
              if (l_q == lrs_pkg::PosW'(1)) begin
                sum_q   <= t_q;
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end else begin
                res_q   <= t_q;
                phase_q <= 1'b1;
                x_q     <= l_q - lrs_pkg::PosW'(1);
                idx_q   <= l_q - lrs_pkg::PosW'(1);
                acc1_q  <= '0;
                acc2_q  <= '0;
                state_q <= S_QRD;
              end
            end else begin
              sum_q   <= res_q - t_q;
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          end
          default: begin
            state_q <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  // a request offered in the same cycle goes first
  assign cfg_ready_o = !busy_o && !start_i;
  assign done_o      = done_q;
  assign range_sum_o = sum_q;

endmodule

@@ rtl/lrs_ram.sv @@
// Single-port storage for the paired Fenwick trees, registered read.
module lrs_ram #(
  parameter int Depth = 1025,
  parameter int AW    = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     addr_i,
  input  lrs_pkg::pair_t    wdata_i,
  output lrs_pkg::pair_t    rdata_o
);

  lrs_pkg::pair_t mem_q [0:Depth-1];
  lrs_pkg::pair_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/lrs_mul.sv @@
// Shared registered multiplier: signed 33 bits by unsigned 12 bits, sign-extended.
module lrs_mul (
  input  logic                              clk_i,
  input  logic signed [lrs_pkg::MulAW-1:0]  a_i,
  input  logic        [lrs_pkg::MulBW-1:0]  b_i,
  output lrs_pkg::sum_t                     p_o
);

  logic signed [lrs_pkg::MulPW-1:0] prod;
  lrs_pkg::sum_t p_d, p_q;

  assign prod = a_i * $signed({1'b0, b_i});
  assign p_d  = {{(lrs_pkg::SumW - lrs_pkg::MulPW){prod[lrs_pkg::MulPW-1]}}, prod};

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

@@ dv/lazy_range_add_sum_tree_checker.sv @@
// Checker for the range-add / range-sum tree: predicts query sums and compares.
`timescale 1ns / 100ps
module lazy_range_add_sum_tree_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic                              cmd_i,
  input  logic [lrs_pkg::FieldW-1:0]        range_left_i,
  input  logic [lrs_pkg::FieldW-1:0]        range_right_i,
  input  logic signed [lrs_pkg::DeltaW-1:0] delta_i,
  input  logic                              done_i,
  input  logic signed [lrs_pkg::SumW-1:0]   range_sum_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [lrs_pkg::FieldW-1:0]        cfg_data_i,
  output int                                err_count_o,
  output int                                pending_o
);
  import lrs_pkg::*;

  localparam int MaxPos = 1024;

  // value held at each position, wrapping at 64 bits
  sum_t pos_val [1:MaxPos];
  int unsigned tree_size;
  sum_t sum_queue[$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count_o++;
  endtask

  function automatic sum_t range_total(input int unsigned lo, input int unsigned hi);
    sum_t acc;
    acc = '0;
    for (int unsigned k = lo; k <= hi; k++) acc += pos_val[k];
    return acc;
  endfunction

  initial begin
    err_count_o = 0;
    tree_size = MaxPos;
    for (int k = 1; k <= MaxPos; k++) pos_val[k] = '0;
  end

  assign pending_o = sum_queue.size();

  always @(posedge clk_i) begin
    int unsigned lo, hi, sz;
    bit in_range;
    sum_t got, exp_sum, ext_delta;
    if (rst_ni) begin
      // result first: it belongs to an earlier request
      if (done_i) begin
        got = range_sum_i;
        if (sum_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", got));
        end else begin
          exp_sum = sum_queue.pop_front();
          if (got !== exp_sum)
            report_mismatch($sformatf("range_sum got %h exp %h", got, exp_sum));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        sz = cfg_data_i;
        if (sz < 1) sz = 1;
        if (sz > MaxPos) sz = MaxPos;
        tree_size = sz;
        for (int k = 1; k <= MaxPos; k++) pos_val[k] = '0;
      end
      if (start_i && !busy_i) begin
        lo = range_left_i;
        hi = range_right_i;
        in_range = (lo >= 1) && (lo <= hi) && (hi <= tree_size);
        if (cmd_i == CmdAdd) begin
          ext_delta = {{(SumW-DeltaW){delta_i[DeltaW-1]}}, delta_i};
          if (in_range)
            for (int unsigned k = lo; k <= hi; k++) pos_val[k] += ext_delta;
        end else begin
          sum_queue.push_back(in_range ? range_total(lo, hi) : sum_t'(0));
        end
      end
    end
  end
endmodule

@@ dv/lazy_range_add_sum_tree_tb.sv @@
// Testbench top for the range-add / range-sum tree: stimulus, watchdog, verdict.
`timescale 1ns / 100ps
module lazy_range_add_sum_tree_tb;
  import lrs_pkg::*;

  localparam int IdlePause = 80;    // adds give no result; let the last one finish
  localparam int StallLimit = 6000; // clearing pass plus pauses, several times over

  logic clk_i, rst_ni, start_i, busy_o, cmd_i, done_o, cfg_valid_i, cfg_ready_o;
  logic [FieldW-1:0] range_left_i, range_right_i, cfg_data_i;
  logic signed [DeltaW-1:0] delta_i;
  logic signed [SumW-1:0] range_sum_o;
  int err_count, pending, stall_cnt, cur_size;

  lazy_range_add_sum_tree u_dut (.*);

  lazy_range_add_sum_tree_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .cmd_i, .range_left_i, .range_right_i,
    .delta_i, .done_i(done_o), .range_sum_i(range_sum_o), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_data_i, .err_count_o(err_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // one request; start stays high into the next one when no gap is drawn
  task automatic send_request(input logic cmd, input int lo, input int hi,
                              input logic [DeltaW-1:0] d);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    cmd_i         <= cmd;
    range_left_i  <= lo[FieldW-1:0];
    range_right_i <= hi[FieldW-1:0];
    delta_i       <= d;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain_requests();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (IdlePause) @(posedge clk_i);
  endtask

  task automatic write_size(input int val);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val[FieldW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_size = (val < 1) ? 1 : (val > 1024) ? 1024 : val;
  endtask

  task automatic random_request();
    int lo, hi;
    logic [DeltaW-1:0] d;
    logic cmd;
    cmd = $urandom_range(0, 1) ? CmdQuery : CmdAdd;
    if ($urandom_range(0, 9) < 8) begin
      lo = $urandom_range(1, cur_size);
      hi = $urandom_range(lo, cur_size);
    end else begin
      // noise: empty, zero-based and out-of-bounds ranges
      lo = $urandom_range(0, 2047);
      hi = $urandom_range(0, 2047);
    end
    case ($urandom_range(0, 3))
      0:       d = $urandom_range(0, 15) - 8;
      1:       d = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: d = $urandom();
    endcase
    send_request(cmd, lo, hi, d);
  endtask

  initial begin
    int sizes[10] = '{1024, 1, 2, 3, 0, 2047, 5, 17, 600, 1024};
    rst_ni = 1'b0;
    start_i = 1'b0;
    cmd_i = CmdAdd;
    range_left_i = '0;
    range_right_i = '0;
    delta_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    cur_size = 1024;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes and special ranges at the reset size
    send_request(CmdAdd, 1, 1024, 32'h7fff_ffff);
    send_request(CmdAdd, 1, 1, 32'h8000_0000);
    send_request(CmdQuery, 1, 1024, '0);
    send_request(CmdQuery, 1024, 1024, '0);
    send_request(CmdQuery, 1, 1, '0);
    send_request(CmdQuery, 9, 8, '0);          // empty range
    send_request(CmdAdd, 9, 8, 32'd5);
    send_request(CmdQuery, 0, 4, '0);          // left below 1
    send_request(CmdAdd, 0, 4, 32'd5);
    send_request(CmdAdd, 3, 1025, 32'd7);      // right past the end
    send_request(CmdQuery, 1, 2047, '0);
    send_request(CmdQuery, 2047, 2047, '0);
    send_request(CmdAdd, 512, 513, 32'hffff_ffff);
    send_request(CmdQuery, 500, 600, '0);
    send_request(CmdQuery, 513, 1024, '0);
    send_request(CmdAdd, 1, 1024, 32'h0);
    send_request(CmdAdd, 1, 1024, 32'h8000_0000);
    send_request(CmdQuery, 1, 1024, '0);
    send_request(CmdQuery, 2, 1023, '0);

    foreach (sizes[ph]) begin
      if (ph > 0) begin
        drain_requests();
        write_size(sizes[ph]);
      end
      repeat (185) random_request();
    end

    drain_requests();
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
